// ===== hw/rtl/rls_pkg.sv =====
// Shared types, register indexes and saturating helpers for the RLS adaptive filter.
// Used by rls_div and rls_adaptive_filter; depends on nothing else.
package rls_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FORGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WLIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSCALE = 2'd3;

    localparam logic [15:0] FORGET_RST = 16'd36045;
    localparam logic [19:0] DIAG_RST   = 20'd10000;
    localparam logic [6:0]  WLIMIT_RST = 7'd100;
    localparam logic [6:0]  OSCALE_RST = 7'd10;

    localparam int S_W     = 48;
    localparam int NUM_W   = 80;
    localparam int DCNT_W  = 7;

    localparam logic signed [63:0] S48_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] S48_MIN64 = 64'shFFFF_8000_0000_0000;
    localparam logic signed [63:0] S16_MAX64 = 64'sd32767;
    localparam logic signed [63:0] S16_MIN64 = -64'sd32768;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] in_sample;
        logic signed [15:0] want_sample;
    } rls_in_t;

    typedef struct packed {
        logic signed [15:0] out_sample;
        logic signed [15:0] pred_error;
    } rls_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRED,
        ST_SCALE,
        ST_SVEC,
        ST_UVEC,
        ST_DOT,
        ST_GAIN,
        ST_GWAIT,
        ST_UPD,
        ST_UWAIT,
        ST_FINISH
    } state_t;

    typedef enum logic {
        DIV_GAIN,
        DIV_LAMBDA
    } div_mode_t;

    typedef struct packed {
        logic               start;
        div_mode_t          mode;
        logic signed [63:0] numer;
        logic [63:0]        denom;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [S_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic logic signed [S_W-1:0] sat48(input logic signed [63:0] v);
        if (v > S48_MAX64)
            return S48_MAX64[S_W-1:0];
        if (v < S48_MIN64)
            return S48_MIN64[S_W-1:0];
        return v[S_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        if (v > S16_MAX64)
            return 16'sh7FFF;
        if (v < S16_MIN64)
            return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== hw/rtl/rls_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the inverse correlation matrix of the filter.
module rls_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 196
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rls_div.sv =====
// Bit-serial restoring divider: |numer| scaled by 2^32 or 2^16 over denom, one bit a cycle.
// Result is truncated toward zero and saturated to 48 bits; uses rls_pkg.
module rls_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rls_pkg::div_req_t req,
    output rls_pkg::div_rsp_t rsp
);

    logic                          busy_reg;
    logic                          fin_reg;
    logic [rls_pkg::DCNT_W-1:0]    cnt_reg;
    logic [rls_pkg::NUM_W-1:0]     num_reg;
    logic [63:0]                   rem_reg;
    logic [63:0]                   den_reg;
    logic [rls_pkg::S_W-1:0]       q_reg;
    logic                          big_reg;
    logic                          neg_reg;

    logic [63:0] mag;
    logic [64:0] trial;
    logic        ge;
    logic        sat;

    assign mag   = req.numer[63] ? (64'd0 - req.numer) : req.numer;
    assign trial = {rem_reg, num_reg[rls_pkg::NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign sat   = big_reg | q_reg[rls_pkg::S_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == rls_pkg::DCNT_W'(rls_pkg::NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= (req.mode == rls_pkg::DIV_GAIN) ? {mag[47:0], 32'd0} : {mag, 16'd0};
            rem_reg <= '0;
            den_reg <= req.denom;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= req.numer[63];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[rls_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            q_reg   <= {q_reg[rls_pkg::S_W-2:0], ge};
            big_reg <= big_reg | q_reg[rls_pkg::S_W-1];
        end
    end

    always_comb
    begin
        rsp.done = fin_reg;
        if (neg_reg)
            rsp.quot = sat ? rls_pkg::S48_MIN64[rls_pkg::S_W-1:0] : (48'd0 - q_reg);
        else
            rsp.quot = sat ? rls_pkg::S48_MAX64[rls_pkg::S_W-1:0] : q_reg;
    end

endmodule

// ===== hw/rtl/rls_adaptive_filter.sv =====
// Top level of the recursive least squares adaptive FIR predictor.
// Depends on rls_pkg, rls_ram (inverse correlation matrix) and rls_div (shared divider).
//
// Usage:
//   samp channel: one beat carries cmd, in_sample and want_sample. cmd low runs one
//   adaptation step and yields exactly one res beat (out_sample, pred_error). cmd high
//   reloads the inverse correlation matrix with the CFG_DIAG value on its diagonal and yields
//   no beat; the tap line and the weights are kept.
//   cfg port: cfg_we writes cfg_data into the register selected by cfg_index; write
//   only while the block is idle.
// Timing:
//   The bit-serial divider retires one quotient bit per cycle and runs once for each
//   gain term and once for each matrix entry update.
//   The matrix passes and the dot product share one 49x17 multiplier.
//   A restart writes one matrix entry per cycle.
// Reset: registers take their default values and a clearing pass over all TAPS^2
//   matrix entries loads the matrix; samp_stall stays high until it is over.
// Stall: a finished result waits in the output register while the next sample is
//   taken; a sample ending while that beat is still stalled waits for it.
module rls_adaptive_filter #(
    parameter int TAPS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               samp_valid,
    output logic                               samp_stall,
    input  rls_pkg::rls_in_t                   samp_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output rls_pkg::rls_out_t                  res_data,
    input  logic                               cfg_we,
    input  logic [rls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH = TAPS * TAPS;
    localparam int IW    = $clog2(TAPS);
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST   = IW'(TAPS - 1);
    localparam logic [AW-1:0] TAPS_A = AW'(TAPS);

    // Configuration registers.
    logic [15:0] ff_reg;
    logic [19:0] diag_cfg_reg;
    logic [6:0]  wlim_reg;
    logic [6:0]  oscale_reg;

    // Sequencer.
    rls_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   m_reg, m_next;
    logic [IW-1:0]   n_reg, n_next;
    logic [2:0]      ph_reg, ph_next;

    // Datapath registers.
    logic signed [63:0] acc_reg, acc_next;
    logic [95:0]        p_reg, p_next;
    logic signed [65:0] prod_reg;
    logic signed [48:0] pred_reg, pred_next;
    logic signed [15:0] want_reg, want_next;
    logic [63:0]        kappa_reg, kappa_next;
    logic signed [15:0] rout_reg, rout_next;
    logic signed [15:0] rerr_reg, rerr_next;
    logic [19:0]        diag_reg, diag_next;
    logic               out_valid_reg, out_valid_next;
    rls_pkg::rls_out_t  out_data_reg, out_data_next;

    logic signed [15:0] tap_reg [TAPS];
    logic signed [31:0] w_reg   [TAPS];
    logic signed [47:0] s_reg   [TAPS];
    logic signed [47:0] uk_reg  [TAPS];

    // Array write strobes.
    logic               tap_shift;
    logic               s_we;
    logic               uk_we;
    logic signed [47:0] uk_wdata;
    logic               w_we;
    logic signed [31:0] w_wdata;

    // Shared multiplier operands.
    logic signed [48:0] mul_a;
    logic signed [16:0] mul_b;

    // Matrix memory.
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [47:0]       ram_wdata;
    logic [47:0]       ram_rdata;
    logic [AW-1:0]     addr_mn;
    logic [AW-1:0]     addr_nm;

    rls_pkg::div_req_t div_req;
    rls_pkg::div_rsp_t div_rsp;

    // Operand selection and arithmetic helpers.
    logic signed [15:0] tap_m, tap_n;
    logic signed [31:0] w_m;
    logic signed [47:0] s_n, uk_m;
    logic [47:0]        kmag, smag;
    logic signed [63:0] prod64;
    logic signed [63:0] acc_sum;
    logic signed [63:0] kappa_raw;
    logic [63:0]        acc_mag, pred_rnd;
    logic signed [48:0] pred_val;
    logic [63:0]        pmag, step_rnd;
    logic signed [63:0] step_val;
    logic signed [63:0] wsum;
    logic signed [63:0] lim64;
    logic [95:0]        p_rnd;
    logic [63:0]        corr_mag;
    logic signed [63:0] corr_val;
    logic signed [63:0] diff_val;
    logic [15:0]        lam;
    logic               last_mn;

    assign tap_m = tap_reg[m_reg];
    assign tap_n = tap_reg[n_reg];
    assign w_m   = w_reg[m_reg];
    assign s_n   = s_reg[n_reg];
    assign uk_m  = uk_reg[m_reg];
    assign kmag  = uk_m[47] ? (48'd0 - uk_m) : uk_m;
    assign smag  = s_n[47] ? (48'd0 - s_n) : s_n;

    assign addr_mn = AW'(m_reg) * TAPS_A + AW'(n_reg);
    assign addr_nm = AW'(n_reg) * TAPS_A + AW'(m_reg);
    assign last_mn = (m_reg == LAST) && (n_reg == LAST);

    assign prod64    = prod_reg[63:0];
    assign acc_sum   = rls_pkg::sadd64(acc_reg, prod64);
    assign kappa_raw = rls_pkg::sadd64($signed({44'd0, ff_reg, 4'd0}), acc_sum);

    // Prediction: accumulated Q.24 sum rounded to an integer, ties away from zero.
    assign acc_mag  = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign pred_rnd = (acc_mag + 64'd8388608) >> 24;
    assign pred_val = acc_reg[63] ? 49'(64'd0 - pred_rnd) : 49'(pred_rnd);

    // Weight step: gain times error over 2^8, rounded the same way.
    assign pmag     = prod64[63] ? (64'd0 - prod64) : prod64;
    assign step_rnd = (pmag + 64'd128) >> 8;
    assign step_val = prod64[63] ? $signed(64'd0 - step_rnd) : $signed(step_rnd);
    assign wsum     = $signed({{32{w_m[31]}}, w_m}) + step_val;
    assign lim64    = $signed({33'd0, wlim_reg, 24'd0});

    // Matrix correction K[m]*s[n] over 2^32, rounded, then subtracted from the entry.
    assign p_rnd    = (p_reg + 96'h0000_0000_0000_0000_8000_0000) >> 32;
    assign corr_mag = p_rnd[63:0];
    assign corr_val = (uk_m[47] ^ s_n[47]) ? $signed(64'd0 - corr_mag) : $signed(corr_mag);
    assign diff_val = $signed({{16{ram_rdata[47]}}, ram_rdata}) - acc_reg;

    assign lam = (ff_reg == 16'd0) ? 16'd1 : ff_reg;

    assign samp_stall = (state_reg != rls_pkg::ST_IDLE);
    assign res_valid  = out_valid_reg;
    assign res_data   = out_data_reg;
    assign ram_raddr  = (state_reg == rls_pkg::ST_SVEC) ? addr_nm : addr_mn;

    rls_ram #(
        .WIDTH (48),
        .DEPTH (DEPTH)
    ) u_mat (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_mn),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Multiplier operand selection; the product is always registered.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rls_pkg::ST_PRED:
            begin
                mul_a = {{17{w_m[31]}}, w_m};
                mul_b = {tap_m[15], tap_m};
            end
            rls_pkg::ST_SCALE:
            begin
                mul_a = pred_reg;
                mul_b = {10'd0, oscale_reg};
            end
            rls_pkg::ST_SVEC, rls_pkg::ST_UVEC:
            begin
                mul_a = {ram_rdata[47], ram_rdata};
                mul_b = {tap_n[15], tap_n};
            end
            rls_pkg::ST_DOT:
            begin
                mul_a = {s_n[47], s_n};
                mul_b = {tap_n[15], tap_n};
            end
            rls_pkg::ST_GAIN:
            begin
                mul_a = {uk_m[47], uk_m};
                mul_b = {rerr_reg[15], rerr_reg};
            end
            rls_pkg::ST_UPD:
            begin
                mul_a = {1'b0, kmag};
                case (ph_reg)
                    3'd0:    mul_b = {1'b0, smag[15:0]};
                    3'd1:    mul_b = {1'b0, smag[31:16]};
                    default: mul_b = {1'b0, smag[47:32]};
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        ph_next        = ph_reg;
        acc_next       = acc_reg;
        p_next         = p_reg;
        pred_next      = pred_reg;
        want_next      = want_reg;
        kappa_next     = kappa_reg;
        rout_next      = rout_reg;
        rerr_next      = rerr_reg;
        diag_next      = diag_reg;
        out_valid_next = out_valid_reg && res_stall;
        out_data_next  = out_data_reg;
        tap_shift      = 1'b0;
        s_we           = 1'b0;
        uk_we          = 1'b0;
        uk_wdata       = div_rsp.quot;
        w_we           = 1'b0;
        w_wdata        = '0;
        ram_we         = 1'b0;
        ram_wdata      = '0;
        div_req        = '0;
        div_req.mode   = rls_pkg::DIV_GAIN;

        case (state_reg)
            rls_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = (m_reg == n_reg) ? {8'd0, diag_reg, 20'd0} : 48'd0;
                if (n_reg == LAST)
                begin
                    n_next = '0;
                    m_next = m_reg + 1'b1;
                    if (m_reg == LAST)
                    begin
                        m_next     = '0;
                        state_next = rls_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    n_next = n_reg + 1'b1;
                end
            end

            rls_pkg::ST_IDLE:
            begin
                m_next  = '0;
                n_next  = '0;
                ph_next = '0;
                if (samp_valid)
                begin
                    if (samp_data.cmd)
                    begin
                        diag_next  = diag_cfg_reg;
                        state_next = rls_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        tap_shift  = 1'b1;
                        want_next  = samp_data.want_sample;
                        acc_next   = '0;
                        state_next = rls_pkg::ST_PRED;
                    end
                end
            end

            rls_pkg::ST_PRED:
            begin
                if (ph_reg == 3'd0)
                begin
                    ph_next = 3'd1;
                end
                else
                begin
                    acc_next = acc_sum;
                    ph_next  = 3'd0;
                    if (m_reg == LAST)
                    begin
                        m_next     = '0;
                        state_next = rls_pkg::ST_SCALE;
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                    end
                end
            end

            rls_pkg::ST_SCALE:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        pred_next = pred_val;
                        ph_next   = 3'd1;
                    end
                    3'd1:
                    begin
                        ph_next = 3'd2;
                    end
                    default:
                    begin
                        rout_next  = rls_pkg::sat16(prod64);
                        rerr_next  = rls_pkg::sat16($signed({{48{want_reg[15]}}, want_reg})
                                                    - $signed({{15{pred_reg[48]}}, pred_reg}));
                        acc_next   = '0;
                        ph_next    = 3'd0;
                        state_next = rls_pkg::ST_SVEC;
                    end
                endcase
            end

            rls_pkg::ST_SVEC, rls_pkg::ST_UVEC:
            begin
                case (ph_reg)
                    3'd0:    ph_next = 3'd1;
                    3'd1:    ph_next = 3'd2;
                    default:
                    begin
                        ph_next = 3'd0;
                        if (n_reg == LAST)
                        begin
                            n_next   = '0;
                            acc_next = '0;
                            if (state_reg == rls_pkg::ST_SVEC)
                                s_we = 1'b1;
                            else
                            begin
                                uk_we    = 1'b1;
                                uk_wdata = rls_pkg::sat48(acc_sum);
                            end
                            if (m_reg == LAST)
                            begin
                                m_next     = '0;
                                state_next = (state_reg == rls_pkg::ST_SVEC) ?
                                             rls_pkg::ST_UVEC : rls_pkg::ST_DOT;
                            end
                            else
                            begin
                                m_next = m_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            acc_next = acc_sum;
                            n_next   = n_reg + 1'b1;
                        end
                    end
                endcase
            end

            rls_pkg::ST_DOT:
            begin
                if (ph_reg == 3'd0)
                begin
                    ph_next = 3'd1;
                end
                else
                begin
                    ph_next = 3'd0;
                    if (n_reg == LAST)
                    begin
                        n_next     = '0;
                        kappa_next = (kappa_raw < 64'sd1) ? 64'd1 : kappa_raw;
                        state_next = rls_pkg::ST_GAIN;
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        n_next   = n_reg + 1'b1;
                    end
                end
            end

            rls_pkg::ST_GAIN:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        div_req.start = 1'b1;
                        div_req.mode  = rls_pkg::DIV_GAIN;
                        div_req.numer = {{16{uk_m[47]}}, uk_m};
                        div_req.denom = kappa_reg;
                        state_next    = rls_pkg::ST_GWAIT;
                    end
                    3'd1:
                    begin
                        ph_next = 3'd2;
                    end
                    default:
                    begin
                        w_we = 1'b1;
                        if (wsum > lim64)
                            w_wdata = lim64[31:0];
                        else if (wsum < -lim64)
                            w_wdata = 32'(-lim64);
                        else
                            w_wdata = wsum[31:0];
                        ph_next = 3'd0;
                        if (m_reg == LAST)
                        begin
                            m_next     = '0;
                            n_next     = '0;
                            state_next = rls_pkg::ST_UPD;
                        end
                        else
                        begin
                            m_next = m_reg + 1'b1;
                        end
                    end
                endcase
            end

            rls_pkg::ST_GWAIT:
            begin
                if (div_rsp.done)
                begin
                    uk_we      = 1'b1;
                    uk_wdata   = div_rsp.quot;
                    ph_next    = 3'd1;
                    state_next = rls_pkg::ST_GAIN;
                end
            end

            rls_pkg::ST_UPD:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        ph_next = 3'd1;
                    end
                    3'd1:
                    begin
                        p_next  = {32'd0, prod_reg[63:0]};
                        ph_next = 3'd2;
                    end
                    3'd2:
                    begin
                        p_next  = p_reg + {16'd0, prod_reg[63:0], 16'd0};
                        ph_next = 3'd3;
                    end
                    3'd3:
                    begin
                        p_next  = p_reg + {prod_reg[63:0], 32'd0};
                        ph_next = 3'd4;
                    end
                    3'd4:
                    begin
                        acc_next = corr_val;
                        ph_next  = 3'd5;
                    end
                    3'd5:
                    begin
                        acc_next = diff_val;
                        ph_next  = 3'd6;
                    end
                    default:
                    begin
                        div_req.start = 1'b1;
                        div_req.mode  = rls_pkg::DIV_LAMBDA;
                        div_req.numer = acc_reg;
                        div_req.denom = {48'd0, lam};
                        ph_next       = 3'd0;
                        state_next    = rls_pkg::ST_UWAIT;
                    end
                endcase
            end

            rls_pkg::ST_UWAIT:
            begin
                if (div_rsp.done)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = div_rsp.quot;
                    if (n_reg == LAST)
                    begin
                        n_next = '0;
                        m_next = m_reg + 1'b1;
                    end
                    else
                    begin
                        n_next = n_reg + 1'b1;
                    end
                    if (last_mn)
                    begin
                        m_next     = '0;
                        state_next = rls_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = rls_pkg::ST_UPD;
                    end
                end
            end

            rls_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.out_sample = rout_reg;
                    out_data_next.pred_error = rerr_reg;
                    state_next               = rls_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rls_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rls_pkg::ST_CLEAR;
            m_reg         <= '0;
            n_reg         <= '0;
            ph_reg        <= '0;
            diag_reg      <= rls_pkg::DIAG_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            ph_reg        <= ph_next;
            diag_reg      <= diag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_reg       <= rls_pkg::FORGET_RST;
            diag_cfg_reg <= rls_pkg::DIAG_RST;
            wlim_reg     <= rls_pkg::WLIMIT_RST;
            oscale_reg   <= rls_pkg::OSCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rls_pkg::CFG_FORGET: ff_reg       <= cfg_data[15:0];
                rls_pkg::CFG_DIAG:   diag_cfg_reg <= cfg_data;
                rls_pkg::CFG_WLIMIT: wlim_reg     <= cfg_data[6:0];
                rls_pkg::CFG_OSCALE: oscale_reg   <= cfg_data[6:0];
                default:             ff_reg       <= ff_reg;
            endcase
        end
    end

    // Tap line and weights start from zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_reg[i] <= '0;
                w_reg[i]   <= '0;
            end
        end
        else
        begin
            if (tap_shift)
            begin
                tap_reg[0] <= samp_data.in_sample;
                for (int i = 1; i < TAPS; i++)
                begin
                    tap_reg[i] <= tap_reg[i-1];
                end
            end
            if (w_we)
            begin
                w_reg[m_reg] <= w_wdata;
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge clk)
    begin
        prod_reg     <= mul_a * mul_b;
        acc_reg      <= acc_next;
        p_reg        <= p_next;
        pred_reg     <= pred_next;
        want_reg     <= want_next;
        kappa_reg    <= kappa_next;
        rout_reg     <= rout_next;
        rerr_reg     <= rerr_next;
        out_data_reg <= out_data_next;
        if (s_we)
        begin
            s_reg[m_reg] <= rls_pkg::sat48(acc_sum);
        end
        if (uk_we)
        begin
            uk_reg[m_reg] <= uk_wdata;
        end
    end

`ifndef SYNTHESIS
    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rls_pkg::ST_FINISH)
        else $error("result beat raised outside the finish step");

    a_gain_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rls_pkg::ST_GWAIT && !div_rsp.done) |=> state_reg == rls_pkg::ST_GWAIT)
        else $error("gain step left before the divider finished");

    a_kappa_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rls_pkg::ST_GAIN) |-> kappa_reg != 64'd0)
        else $error("gain divisor is zero");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_reg <= LAST) && (n_reg <= LAST))
        else $error("matrix index out of range");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for rls_adaptive_filter: random and directed sample beats,
// a fixed-point predictor of the adaptation step and a beat-by-beat result check.
// Depends on rls_pkg and the rls_adaptive_filter RTL.
module testbench;
    import rls_pkg::*;

    localparam int TAPS = 14;
    localparam int IDLE_LIMIT = 400000;   // cycles with no beat before giving up
    localparam int HOLD_CYCLES = 60000;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 500;    // covers a trailing restart
    localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_LO = 64'shFFFF_8000_0000_0000;
    localparam longint MAG_CAP = 64'sh4000_0000_0000_0000;

    logic clk;
    logic rst_n;
    logic samp_valid;
    logic samp_stall;
    rls_in_t samp_data;
    logic res_valid;
    logic res_stall;
    rls_out_t res_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rls_adaptive_filter #(.TAPS(TAPS)) dut (
        .clk(clk), .rst_n(rst_n),
        .samp_valid(samp_valid), .samp_stall(samp_stall), .samp_data(samp_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state: tap line, Q8.24 weights and the Q28.20 inverse correlation matrix.
    logic signed [15:0] tap_hist[TAPS];
    logic signed [31:0] weight_q[TAPS];
    logic signed [47:0] corr_q[TAPS][TAPS];
    logic [15:0] lambda_reg;
    logic [19:0] diag_reg;
    logic [6:0] wlimit_reg;
    logic [6:0] oscale_reg;

    rls_in_t pending_beats[$];
    rls_out_t expected_results[$];
    int failures;
    int idle_cycles;
    bit sender_calm;
    bit receiver_calm;
    int hold_requests;
    int hold_served;

    initial begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // Fixed-point helpers. Magnitudes are worked out in 128 bits, then the
    // result is capped at 2^62 and given its sign.
    // ---------------------------------------------------------------------
    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_capped(input logic [127:0] m, input bit neg);
        logic [127:0] c;
        c = (m > 128'(MAG_CAP)) ? 128'(MAG_CAP) : m;
        return neg ? -longint'(c[63:0]) : longint'(c[63:0]);
    endfunction

    // round(a*b / 2^sh), ties away from zero
    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        if (p[127:64] != 64'd0)
            p = 128'(MAG_CAP);
        return signed_capped(p, (a < 0) != (b < 0));
    endfunction

    // (n * 2^sh) / d, truncated toward zero, d >= 1
    function automatic longint div_trunc(input longint n, input int sh, input longint d);
        logic [127:0] q;
        q = ({64'd0, magnitude(n)} << sh) / {64'd0, 64'(d)};
        return signed_capped(q, n < 0);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic longint limit(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void reload_diag();
        for (int m = 0; m < TAPS; m++)
            for (int n = 0; n < TAPS; n++)
                corr_q[m][n] = (m == n) ? 48'(longint'(diag_reg) << 20) : 48'sd0;
    endfunction

    // One adaptation step: shift in the sample, predict, then update gain,
    // weights and the inverse correlation matrix. A restart only reloads the matrix.
    task automatic predict_step(input rls_in_t b);
        longint s_vec[TAPS];
        longint u_vec[TAPS];
        longint gain[TAPS];
        longint acc, pred, outv, err, dot, kappa, lam, lim, as_sum, au_sum, diff;
        rls_out_t r;
        if (b.cmd) begin
            reload_diag();
            return;
        end
        for (int m = TAPS - 1; m > 0; m--)
            tap_hist[m] = tap_hist[m - 1];
        tap_hist[0] = b.in_sample;

        acc = 0;
        for (int m = 0; m < TAPS; m++)
            acc += longint'(tap_hist[m]) * longint'(weight_q[m]);
        pred = mul_round(acc, 1, 24);
        outv = limit(pred * longint'(oscale_reg), -32768, 32767);
        err = limit(longint'(b.want_sample) - pred, -32768, 32767);

        for (int m = 0; m < TAPS; m++) begin
            as_sum = 0;
            au_sum = 0;
            for (int n = 0; n < TAPS; n++) begin
                as_sum = add_sat(as_sum, longint'(tap_hist[n]) * longint'(corr_q[n][m]));
                au_sum = add_sat(au_sum, longint'(corr_q[m][n]) * longint'(tap_hist[n]));
            end
            s_vec[m] = limit(as_sum, S48_LO, S48_HI);
            u_vec[m] = limit(au_sum, S48_LO, S48_HI);
        end
        dot = 0;
        for (int n = 0; n < TAPS; n++)
            dot = add_sat(dot, s_vec[n] * longint'(tap_hist[n]));
        kappa = add_sat(longint'(lambda_reg) << 4, dot);
        if (kappa < 1)
            kappa = 1;

        lim = longint'(wlimit_reg) << 24;
        for (int m = 0; m < TAPS; m++) begin
            gain[m] = limit(div_trunc(u_vec[m], 32, kappa), S48_LO, S48_HI);
            weight_q[m] = 32'(limit(add_sat(longint'(weight_q[m]),
                                            mul_round(gain[m], err, 8)), -lim, lim));
        end

        // A zero forgetting factor acts as one LSB.
        lam = (lambda_reg == 16'd0) ? 1 : longint'(lambda_reg);
        for (int m = 0; m < TAPS; m++)
            for (int n = 0; n < TAPS; n++) begin
                diff = add_sat(longint'(corr_q[m][n]), -mul_round(gain[m], s_vec[n], 32));
                corr_q[m][n] = 48'(limit(div_trunc(diff, 16, lam), S48_LO, S48_HI));
            end

        r.out_sample = outv[15:0];
        r.pred_error = err[15:0];
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        failures++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // ---------------------------------------------------------------------
    // Sender: offers queued beats and holds each one steady while stalled.
    // The predictor runs on every accepted beat.
    // ---------------------------------------------------------------------
    int send_gap;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            samp_valid <= 1'b0;
            samp_data <= '0;
            send_gap <= 0;
        end else begin
            if (samp_valid && !samp_stall)
                predict_step(samp_data);
            if (samp_valid && samp_stall) begin
                // Beat is held until the block takes it.
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                samp_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                samp_data <= pending_beats.pop_front();
                samp_valid <= 1'b1;
                send_gap <= sender_calm ? 0 : pick_gap();
            end else begin
                samp_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the block
    // fills up and stalls its input.
    // ---------------------------------------------------------------------
    int stall_left;
    int hold_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
            hold_served <= 0;
        end else if (hold_requests > hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            res_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_stall <= 1'b1;
        end else if (!receiver_calm && $urandom_range(0, 99) < 30) begin
            stall_left <= pick_gap();
            res_stall <= 1'b1;
        end else begin
            res_stall <= 1'b0;
        end
    end

    // Result checker: every accepted result beat against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result beat with nothing expected", $realtime);
            end else begin
                rls_out_t want;
                want = expected_results.pop_front();
                if (res_data.out_sample !== want.out_sample)
                    report_mismatch("out_sample", res_data.out_sample, want.out_sample);
                if (res_data.pred_error !== want.pred_error)
                    report_mismatch("pred_error", res_data.pred_error, want.pred_error);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel.
    always @(posedge clk) begin
        if ((samp_valid && !samp_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("rls_adaptive_filter verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] lam, input logic [19:0] diag,
                              input logic [6:0] wlim, input logic [6:0] oscale);
        write_reg(CFG_FORGET, 20'(lam));
        write_reg(CFG_DIAG, diag);
        write_reg(CFG_WLIMIT, 20'(wlim));
        write_reg(CFG_OSCALE, 20'(oscale));
        lambda_reg = lam;
        diag_reg = diag;
        wlimit_reg = wlim;
        oscale_reg = oscale;
    endtask

    // Waits until every beat is sent and answered, then lets a trailing restart finish.
    task automatic drain();
        while (pending_beats.size() > 0 || samp_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic rls_in_t make_beat(input bit restart, input int signed a,
                                          input int signed w);
        rls_in_t b;
        b.cmd = restart;
        b.in_sample = 16'(a);
        b.want_sample = 16'(w);
        return b;
    endfunction

    // Random beats: most are a sampled signal with a related desired sample
    // (so the weights actually converge), the rest full-range noise or restarts.
    task automatic queue_random(input int count);
        int signed x, prev, amp;
        prev = 0;
        amp = $urandom_range(1, 2000);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0: pending_beats.push_back(make_beat(1'b1, $urandom, $urandom));
                1, 2, 3, 4:
                    pending_beats.push_back(make_beat(1'b0, $urandom, $urandom));
                default: begin
                    x = $urandom_range(0, 2 * amp) - amp;
                    pending_beats.push_back(make_beat(1'b0, x,
                        prev + x / 2 + int'($urandom_range(0, 20)) - 10));
                    prev = x;
                end
            endcase
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        failures = 0;
        idle_cycles = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        hold_requests = 0;
        lambda_reg = FORGET_RST;
        diag_reg = DIAG_RST;
        wlimit_reg = WLIMIT_RST;
        oscale_reg = OSCALE_RST;
        for (int m = 0; m < TAPS; m++) begin
            tap_hist[m] = '0;
            weight_q[m] = '0;
        end
        reload_diag();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats at reset defaults: field extremes, bit patterns, restarts.
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        pending_beats.push_back(make_beat(1'b0, 32767, 32767));
        pending_beats.push_back(make_beat(1'b0, -32768, -32768));
        pending_beats.push_back(make_beat(1'b0, 0, 0));
        pending_beats.push_back(make_beat(1'b0, 32767, -32768));
        pending_beats.push_back(make_beat(1'b0, -32768, 32767));
        pending_beats.push_back(make_beat(1'b0, 16'h5555, 16'hAAAA));
        pending_beats.push_back(make_beat(1'b0, 16'hAAAA, 16'h5555));
        pending_beats.push_back(make_beat(1'b1, 32767, -32768));
        pending_beats.push_back(make_beat(1'b0, 1, -1));
        pending_beats.push_back(make_beat(1'b0, -1, 1));
        pending_beats.push_back(make_beat(1'b0, 100, 200));
        pending_beats.push_back(make_beat(1'b0, 100, 200));
        pending_beats.push_back(make_beat(1'b0, -32768, 0));
        pending_beats.push_back(make_beat(1'b0, 0, 32767));
        pending_beats.push_back(make_beat(1'b1, -1, -1));
        pending_beats.push_back(make_beat(1'b0, 32767, 0));
        pending_beats.push_back(make_beat(1'b0, 0, -32768));
        drain();

        // Defaults written back explicitly, with the long receiver hold-off.
        set_config(FORGET_RST, DIAG_RST, WLIMIT_RST, OSCALE_RST);
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        queue_random(120);
        hold_requests = hold_requests + 1;
        // Stimulus waits until at most 60 beats are unsent, then until everything has come back.
        while (pending_beats.size() > 60) @(posedge clk);
        while (samp_valid || expected_results.size() > 0) @(posedge clk);
        drain();

        // Top of the documented ranges, calm handshakes.
        sender_calm = 1'b1;
        receiver_calm = 1'b1;
        set_config(16'd65535, 20'd1000000, 7'd127, 7'd64);
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        queue_random(110);
        drain();
        sender_calm = 1'b0;
        receiver_calm = 1'b0;

        // Bottom of the ranges.
        set_config(16'd1, 20'd1, 7'd1, 7'd1);
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        queue_random(110);
        drain();

        // Zero forgetting factor, zero weight limit, zero output scale.
        set_config(16'd0, 20'd0, 7'd0, 7'd0);
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        queue_random(100);
        drain();

        // All-ones register values.
        set_config(16'hFFFF, 20'hFFFFF, 7'h7F, 7'h7F);
        pending_beats.push_back(make_beat(1'b1, 0, 0));
        queue_random(100);
        drain();

        // Random settings within the documented ranges.
        for (int p = 0; p < 2; p++) begin
            set_config(16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1000000)),
                       7'($urandom_range(1, 127)), 7'($urandom_range(1, 64)));
            pending_beats.push_back(make_beat(1'b1, 0, 0));
            queue_random(100);
            drain();
        end

        if (failures == 0)
            $display("rls_adaptive_filter verification clean");
        else
            $display("rls_adaptive_filter verification failed");
        $finish;
    end

endmodule
